// File: design/cgb_pkg.sv
// ----------------------------------------------------------------------------
// cgb_pkg: shared types and constants of the glyph blitter
// Field widths, register indexes, action codes and the row issue bundle.
// ----------------------------------------------------------------------------
package cgb_pkg;

  localparam int GLYPH_ROWS  = 16;
  localparam int GLYPH_COUNT = 256;
  localparam int MAX_RESULTS = 16;
  localparam int STORE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int ROW_W       = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int GLYPH_W     = 8;
  localparam int BYTE_W      = 8;
  localparam int POS_W       = 16;
  localparam int COLOR_W     = 32;
  localparam int IDX_W       = 32;
  localparam int CROP_W      = 15;
  localparam int PITCH_W     = 16;
  localparam int Y_W         = POS_W + 1;   // pos_y plus row offset
  localparam int CMP_W       = POS_W + 2;   // signed compare width
  localparam int CFG_IDX_W   = 3;

  localparam logic [PITCH_W-1:0] PITCH_RESET = PITCH_W'(640);

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_DRAW = 1'b1
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CROP_LEFT   = 3'd0,
    REG_CROP_TOP    = 3'd1,
    REG_CROP_WIDTH  = 3'd2,
    REG_CROP_HEIGHT = 3'd3,
    REG_LINE_PITCH  = 3'd4
  } cfg_reg_t;

  // one glyph row handed from the sequencer to the row pipeline
  typedef struct packed {
    logic                valid;
    logic                last;
    logic [Y_W-1:0]      y;
    logic [7:0]          col_mask;
    logic [POS_W-1:0]    px;
    logic [COLOR_W-1:0]  color;
  } row_issue_t;

  function automatic logic [GLYPH_W-1:0] glyph_wrap(input logic [GLYPH_W-1:0] g);
    glyph_wrap = GLYPH_W'(g % GLYPH_COUNT);
  endfunction

endpackage

// File: design/clipped_glyph_blitter_top.sv
// ----------------------------------------------------------------------------
// clipped_glyph_blitter_top: clipped 8x16 bitmap font glyph blitter
// Font store load, per-row clipping, row index multiply, masked row writes.
// ----------------------------------------------------------------------------
// Rows of a draw come out in row order through stage 1, stage 2 and the output register.
// A draw holds in_ready low while it walks the glyph rows, one font-row read per cycle
//   while the output does not stall, ending at the last visible row or the last glyph row; a load never holds it low.
// Output stalls freeze the whole row pipeline and the sequencer with it.
// Reset (rst_n low at a clock edge) clears control and config registers;
//   the font store is not cleared and must be loaded before use.
module clipped_glyph_blitter_top import cgb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // item input
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_action,
  input  logic [ADDR_W-1:0]    in_font_address,
  input  logic [BYTE_W-1:0]    in_font_byte,
  input  logic [GLYPH_W-1:0]   in_glyph_code,
  input  logic [POS_W-1:0]     in_pos_x,
  input  logic [POS_W-1:0]     in_pos_y,
  input  logic [COLOR_W-1:0]   in_color,
  // row write output
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [IDX_W-1:0]     out_frame_index,
  output logic [7:0]           out_pixel_mask,
  output logic [COLOR_W-1:0]   out_pixel_color,
  output logic                 out_is_last,
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PITCH_W-1:0]   cfg_data
);

  logic [CROP_W-1:0]  crop_left_r;
  logic [CROP_W-1:0]  crop_top_r;
  logic [CROP_W-1:0]  crop_width_r;
  logic [CROP_W-1:0]  crop_height_r;
  logic [PITCH_W-1:0] line_pitch_r;

  logic               cfg_we;
  logic               load_we;
  logic               adv;
  row_issue_t         iss;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [BYTE_W-1:0]  font_bits;

  // register port never stalls
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crop_left_r   <= '0;
      crop_top_r    <= '0;
      crop_width_r  <= '0;
      crop_height_r <= '0;
      line_pitch_r  <= PITCH_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_CROP_LEFT:   crop_left_r   <= cfg_data[CROP_W-1:0];
        REG_CROP_TOP:    crop_top_r    <= cfg_data[CROP_W-1:0];
        REG_CROP_WIDTH:  crop_width_r  <= cfg_data[CROP_W-1:0];
        REG_CROP_HEIGHT: crop_height_r <= cfg_data[CROP_W-1:0];
        REG_LINE_PITCH:  line_pitch_r  <= cfg_data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // load items go straight into the font store on accept
  assign load_we = in_valid && in_ready && (in_action == ACT_LOAD);

  cgb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_font_store (
    .clk   (clk),
    .we    (load_we),
    .waddr (in_font_address),
    .wdata (in_font_byte),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (font_bits)
  );

  // row walker: one glyph row per cycle while the pipeline advances, invisible rows drop out here
  cgb_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_action     (in_action),
    .in_glyph_code (in_glyph_code),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_color      (in_color),
    .crop_left     (crop_left_r),
    .crop_top      (crop_top_r),
    .crop_width    (crop_width_r),
    .crop_height   (crop_height_r),
    .adv           (adv),
    .iss           (iss),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr)
  );

  // mask, y*pitch, +pos_x, output register
  cgb_pipe u_pipe (
    .clk             (clk),
    .rst_n           (rst_n),
    .iss             (iss),
    .font_bits       (font_bits),
    .line_pitch      (line_pitch_r),
    .adv             (adv),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_frame_index (out_frame_index),
    .out_pixel_mask  (out_pixel_mask),
    .out_pixel_color (out_pixel_color),
    .out_is_last     (out_is_last)
  );

endmodule

// File: design/cgb_ram.sv
// ----------------------------------------------------------------------------
// cgb_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cgb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/cgb_seq.sv
// ----------------------------------------------------------------------------
// cgb_seq: input sequencer
// Takes items, walks a draw glyph one row per cycle while the row pipeline advances, issues visible rows.
// ----------------------------------------------------------------------------
module cgb_seq import cgb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_action,
  input  logic [GLYPH_W-1:0]   in_glyph_code,
  input  logic [POS_W-1:0]     in_pos_x,
  input  logic [POS_W-1:0]     in_pos_y,
  input  logic [COLOR_W-1:0]   in_color,
  input  logic [CROP_W-1:0]    crop_left,
  input  logic [CROP_W-1:0]    crop_top,
  input  logic [CROP_W-1:0]    crop_width,
  input  logic [CROP_W-1:0]    crop_height,
  input  logic                 adv,
  output row_issue_t           iss,
  output logic                 rd_en,
  output logic [ADDR_W-1:0]    rd_addr
);

  localparam int FA_W = GLYPH_W + ROW_W + ADDR_W;
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GLYPH_ROWS - 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_RESULTS - 1);

  logic                busy_r, busy_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [GLYPH_W-1:0]  glyph_r;
  logic [POS_W-1:0]    px_r;
  logic [Y_W-1:0]      y_r, y_nxt;
  logic [COLOR_W-1:0]  color_r;

  logic                take;
  logic                step;
  logic signed [CMP_W-1:0] y_s, y1_s, ytop_s, yend_s, xl_s, xr_s;
  logic                vis;
  logic                last;
  logic [7:0]          col_mask;
  logic [FA_W-1:0]     fa;

  assign in_ready = !busy_r;
  assign take     = in_valid && in_ready && (in_action == ACT_DRAW);
  assign step     = busy_r && adv;

  assign y_s    = $signed({y_r[Y_W-1], y_r});
  assign y1_s   = y_s + CMP_W'(1);
  assign ytop_s = $signed(CMP_W'(crop_top));
  assign yend_s = $signed(CMP_W'({1'b0, crop_top} + {1'b0, crop_height}));
  assign xl_s   = $signed(CMP_W'(crop_left));
  assign xr_s   = $signed(CMP_W'({1'b0, crop_left} + {1'b0, crop_width}));

  assign vis  = (y_s >= ytop_s) && (y_s < yend_s);
  assign last = vis && ((row_r == ROW_LAST) || (y1_s >= yend_s) || (cnt_r == CNT_LAST));

  // horizontal crop: bit 7-j covers column pos_x+j
  always_comb begin
    logic signed [CMP_W-1:0] x;
    col_mask = '0;
    for (int j = 0; j < 8; j++) begin
      x = $signed({{2{px_r[POS_W-1]}}, px_r}) + CMP_W'(j);
      col_mask[7-j] = (x >= xl_s) && (x < xr_s);
    end
  end

  assign fa      = FA_W'(glyph_r) * FA_W'(GLYPH_ROWS) + FA_W'(row_r);
  assign rd_addr = fa[ADDR_W-1:0];
  assign rd_en   = adv;

  always_comb begin
    iss.valid    = step && vis;
    iss.last     = last;
    iss.y        = y_r;
    iss.col_mask = col_mask;
    iss.px       = px_r;
    iss.color    = color_r;
  end

  always_comb begin
    busy_nxt = busy_r;
    row_nxt  = row_r;
    cnt_nxt  = cnt_r;
    y_nxt    = y_r;
    if (take) begin
      busy_nxt = 1'b1;
      row_nxt  = '0;
      cnt_nxt  = '0;
      y_nxt    = {in_pos_y[POS_W-1], in_pos_y};
    end else if (step) begin
      row_nxt  = row_r + 1'b1;
      cnt_nxt  = cnt_r + CNT_W'(vis);
      y_nxt    = y_r + 1'b1;
      busy_nxt = !((row_r == ROW_LAST) || last);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
    cnt_r <= cnt_nxt;
    y_r   <= y_nxt;
    if (take) begin
      glyph_r <= glyph_wrap(in_glyph_code);
      px_r    <= in_pos_x;
      color_r <= in_color;
    end
  end

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (step && last) |=> !busy_r)
    else $error("glyph walk continued past its last visible row");

  a_no_idle_issue: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> !iss.valid)
    else $error("row issued while sequencer idle");

  a_draw_starts: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> (busy_r && (row_r == '0) && (cnt_r == '0)))
    else $error("draw item did not start a glyph walk");

endmodule

// File: design/cgb_pipe.sv
// ----------------------------------------------------------------------------
// cgb_pipe: row pipeline
// Mask and row multiply, index add, output register; stalls as one.
// ----------------------------------------------------------------------------
module cgb_pipe import cgb_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  row_issue_t          iss,
  input  logic [BYTE_W-1:0]   font_bits,
  input  logic [PITCH_W-1:0]  line_pitch,
  output logic                adv,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [IDX_W-1:0]    out_frame_index,
  output logic [7:0]          out_pixel_mask,
  output logic [COLOR_W-1:0]  out_pixel_color,
  output logic                out_is_last
);

  localparam int PROD_W = Y_W + PITCH_W + 1;

  // stage 1: issued row, font byte arrives from the RAM
  logic                s1_valid_r;
  row_issue_t          s1_r;
  // stage 2: masked row, row product
  logic                s2_valid_r;
  logic [IDX_W-1:0]    s2_prod_r;
  logic [7:0]          s2_mask_r;
  logic [POS_W-1:0]    s2_px_r;
  logic [COLOR_W-1:0]  s2_color_r;
  logic                s2_last_r;
  // stage 3: output register
  logic                s3_valid_r;
  logic [IDX_W-1:0]    s3_idx_r;
  logic [7:0]          s3_mask_r;
  logic [COLOR_W-1:0]  s3_color_r;
  logic                s3_last_r;

  logic signed [PROD_W-1:0] prod;
  logic [IDX_W-1:0]         idx_nxt;

  assign adv = !s3_valid_r || out_ready;

  assign prod    = $signed(s1_r.y) * $signed({1'b0, line_pitch});
  assign idx_nxt = s2_prod_r + {{(IDX_W-POS_W){s2_px_r[POS_W-1]}}, s2_px_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= iss.valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r       <= iss;
      s2_prod_r  <= prod[IDX_W-1:0];
      s2_mask_r  <= font_bits & s1_r.col_mask;
      s2_px_r    <= s1_r.px;
      s2_color_r <= s1_r.color;
      s2_last_r  <= s1_r.last;
      s3_idx_r   <= idx_nxt;
      s3_mask_r  <= s2_mask_r;
      s3_color_r <= s2_color_r;
      s3_last_r  <= s2_last_r;
    end
  end

  assign out_valid       = s3_valid_r;
  assign out_frame_index = s3_idx_r;
  assign out_pixel_mask  = s3_mask_r;
  assign out_pixel_color = s3_color_r;
  assign out_is_last     = s3_last_r;

  a_stall_keeps_s2: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !adv) |=> s2_valid_r)
    else $error("row lost in stage 2 during stall");

  a_stall_keeps_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |=> (s1_valid_r && $stable(s1_r)))
    else $error("row in stage 1 changed during stall");

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the clipped glyph blitter
// Loads font rows and draws glyphs under several crop windows and pitches.
// A scoreboard predicts every row write and checks results in order, while
// both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import cgb_pkg::*;

  // one item on the input channel
  typedef struct {
    action_t              action;
    logic [ADDR_W-1:0]    font_address;
    logic [BYTE_W-1:0]    font_byte;
    logic [GLYPH_W-1:0]   glyph_code;
    logic [POS_W-1:0]     pos_x;
    logic [POS_W-1:0]     pos_y;
    logic [COLOR_W-1:0]   color;
  } blit_item_t;

  // one framebuffer row write on the result channel
  typedef struct {
    logic [IDX_W-1:0]     index;
    logic [7:0]           mask;
    logic [COLOR_W-1:0]   color;
    logic                 last;
  } row_write_t;

  // Shadow of the font store and crop registers; turns every accepted item
  // into the row writes it must produce, then checks writes in arrival order.
  class row_write_checker;
    logic [7:0]  font_shadow [STORE_DEPTH];
    int          crop_left, crop_top, crop_width, crop_height, line_pitch;
    row_write_t  due_writes[$];
    int          errors;

    function new();
      foreach (font_shadow[i]) font_shadow[i] = '0;
      crop_left   = 0;
      crop_top    = 0;
      crop_width  = 0;
      crop_height = 0;
      line_pitch  = int'(PITCH_RESET);
      errors      = 0;
    endfunction

    function void write_reg(cfg_reg_t r, logic [PITCH_W-1:0] d);
      case (r)
        REG_CROP_LEFT:   crop_left   = int'(d[CROP_W-1:0]);
        REG_CROP_TOP:    crop_top    = int'(d[CROP_W-1:0]);
        REG_CROP_WIDTH:  crop_width  = int'(d[CROP_W-1:0]);
        REG_CROP_HEIGHT: crop_height = int'(d[CROP_W-1:0]);
        REG_LINE_PITCH:  line_pitch  = int'(d);
        default: ;
      endcase
    endfunction

    function void note_item(blit_item_t it);
      int          glyph, px, py, y, x, row, nrows;
      logic [7:0]  bits, mask;
      row_write_t  w, held;
      bit          have_held;
      have_held = 1'b0;
      nrows = 0;
      if (it.action == ACT_LOAD) begin
        font_shadow[it.font_address] = it.font_byte;
        return;
      end
      glyph = int'(it.glyph_code) % GLYPH_COUNT;
      px = shortint'(it.pos_x);
      py = shortint'(it.pos_y);
      for (row = 0; row < GLYPH_ROWS && nrows < MAX_RESULTS; row++) begin
        y = py + row;
        if (y >= crop_top && y < crop_top + crop_height) begin
          bits = font_shadow[(glyph * GLYPH_ROWS + row) % STORE_DEPTH];
          mask = '0;
          for (int j = 0; j < 8; j++) begin
            x = px + j;
            if (x >= crop_left && x < crop_left + crop_width && bits[7-j])
              mask[7-j] = 1'b1;
          end
          w.index = y * line_pitch + px;   // 32-bit wrap is intended
          w.mask  = mask;
          w.color = it.color;
          w.last  = 1'b0;
          // hold one row back so the final one can be flagged
          if (have_held) due_writes.push_back(held);
          held = w;
          have_held = 1'b1;
          nrows++;
        end
      end
      if (have_held) begin
        held.last = 1'b1;
        due_writes.push_back(held);
      end
    endfunction

    function void check_write(row_write_t got);
      row_write_t want;
      if (due_writes.size() == 0) begin
        errors++;
        $display("%0t: unexpected row write index=%h mask=%h color=%h last=%b",
                 $time, got.index, got.mask, got.color, got.last);
        return;
      end
      want = due_writes.pop_front();
      if (got.index !== want.index) begin
        errors++;
        $display("%0t: frame_index expected %h, got %h", $time, want.index, got.index);
      end
      if (got.mask !== want.mask) begin
        errors++;
        $display("%0t: pixel_mask expected %h, got %h", $time, want.mask, got.mask);
      end
      if (got.color !== want.color) begin
        errors++;
        $display("%0t: pixel_color expected %h, got %h", $time, want.color, got.color);
      end
      if (got.last !== want.last) begin
        errors++;
        $display("%0t: is_last expected %b, got %b", $time, want.last, got.last);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_action = 1'b0;
  logic [ADDR_W-1:0]    in_font_address = '0;
  logic [BYTE_W-1:0]    in_font_byte = '0;
  logic [GLYPH_W-1:0]   in_glyph_code = '0;
  logic [POS_W-1:0]     in_pos_x = '0;
  logic [POS_W-1:0]     in_pos_y = '0;
  logic [COLOR_W-1:0]   in_color = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [IDX_W-1:0]     out_frame_index;
  logic [7:0]           out_pixel_mask;
  logic [COLOR_W-1:0]   out_pixel_color;
  logic                 out_is_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_CROP_LEFT;
  logic [PITCH_W-1:0]   cfg_data = '0;

  row_write_checker sb;
  bit   tx_idle = 1'b1;       // sender inserts random gaps
  bit   rx_idle = 1'b1;       // receiver inserts random stalls
  int   item_count = 0;
  bit   glyph_ready [GLYPH_COUNT];
  int   ready_glyphs[$];      // glyphs with all rows loaded

  clipped_glyph_blitter_top DUT (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop in case a handshake never completes
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Input side. Everything is driven at the falling edge; handshakes are
  // sampled right after the rising edge, so pre-edge values are seen.
  // --------------------------------------------------------------------------

  // random idle gap ahead of the next item, while gaps are enabled
  task automatic idle_gap();
    int n;
    n = tx_idle ? $urandom_range(13) : 0;
    if (n > 0) begin
      in_valid = 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // present one item, hold it until taken, then hand it to the scoreboard
  task automatic send_item(blit_item_t it);
    idle_gap();
    in_action       = it.action;
    in_font_address = it.font_address;
    in_font_byte    = it.font_byte;
    in_glyph_code   = it.glyph_code;
    in_pos_x        = it.pos_x;
    in_pos_y        = it.pos_y;
    in_color        = it.color;
    in_valid        = 1'b1;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    sb.note_item(it);
    item_count++;
    // alternate stretches with and without gaps
    if (item_count % 40 == 0) tx_idle = ($urandom_range(2) != 0);
    @(negedge clk);
  endtask

  // fields that the action does not use still carry random bits
  function automatic blit_item_t random_item(action_t act);
    blit_item_t it;
    it.action       = act;
    it.font_address = ADDR_W'($urandom);
    it.font_byte    = BYTE_W'($urandom);
    it.glyph_code   = GLYPH_W'($urandom);
    it.pos_x        = POS_W'($urandom);
    it.pos_y        = POS_W'($urandom);
    it.color        = $urandom;
    return it;
  endfunction

  task automatic load_byte(int addr, logic [7:0] b);
    blit_item_t it;
    it = random_item(ACT_LOAD);
    it.font_address = ADDR_W'(addr);
    it.font_byte    = b;
    send_item(it);
  endtask

  task automatic draw_glyph(int g, int x, int y, logic [31:0] c);
    blit_item_t it;
    it = random_item(ACT_DRAW);
    it.glyph_code = GLYPH_W'(g);
    it.pos_x      = POS_W'(x);
    it.pos_y      = POS_W'(y);
    it.color      = c;
    send_item(it);
  endtask

  // all sixteen rows of one glyph, biased toward empty and solid rows
  task automatic load_glyph(int g);
    logic [7:0] b;
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      case ($urandom_range(3))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        default: b = 8'($urandom);
      endcase
      load_byte(g * GLYPH_ROWS + r, b);
    end
    if (!glyph_ready[g]) begin
      glyph_ready[g] = 1'b1;
      ready_glyphs.push_back(g);
    end
  endtask

  // Wait until every predicted write has come back, then give the block time
  // to finish a draw with no visible rows. Leaves the bench at a falling edge.
  task automatic drain();
    in_valid = 1'b0;
    for (int k = 0; k < 100000 && sb.due_writes.size() != 0; k++) @(posedge clk);
    repeat (GLYPH_ROWS + 8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(cfg_reg_t r, logic [PITCH_W-1:0] d);
    cfg_index = r;
    cfg_data  = d;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    sb.write_reg(r, d);
    @(negedge clk);
  endtask

  // crop values above 15 bits are passed through; the block keeps 15
  task automatic set_window(int left, int top, int width, int height, int pitch);
    cfg_write(REG_CROP_LEFT,   PITCH_W'(left));
    cfg_write(REG_CROP_TOP,    PITCH_W'(top));
    cfg_write(REG_CROP_WIDTH,  PITCH_W'(width));
    cfg_write(REG_CROP_HEIGHT, PITCH_W'(height));
    cfg_write(REG_LINE_PITCH,  PITCH_W'(pitch));
    cfg_valid = 1'b0;
  endtask

  // coordinate around a crop edge, so glyphs straddle the window borders
  function automatic int near_edge(int base, int span, int lead);
    int s;
    s = (span > 40) ? 40 : span;
    return base - lead + int'($urandom_range(s + lead + 4));
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random stall before each write, then ready until one lands
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int         stall;
    int         taken;
    row_write_t got;
    taken = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = rx_idle ? $urandom_range(13) : 0;
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      got.index = out_frame_index;
      got.mask  = out_pixel_mask;
      got.color = out_pixel_color;
      got.last  = out_is_last;
      sb.check_write(got);
      taken++;
      if (taken % 25 == 0) rx_idle = ($urandom_range(2) != 0);
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [7:0] row_art [16];
    int         phase, phase_end, pick, g, x, y;
    row_art = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55, 8'hF0, 8'h0F,
                8'h3C, 8'hC3, 8'h18, 8'h7E, 8'h81, 8'hE7, 8'h42, 8'hFF};
    sb = new();

    // synchronous reset, released at a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Font setup: the first and last glyph, which also hits store
    // addresses zero and all-ones. Only fully loaded glyphs are ever drawn.
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      load_byte(r, row_art[r]);
      load_byte((GLYPH_COUNT - 1) * GLYPH_ROWS + r, ~row_art[15 - r]);
    end
    glyph_ready[0] = 1'b1;
    glyph_ready[GLYPH_COUNT - 1] = 1'b1;
    ready_glyphs.push_back(0);
    ready_glyphs.push_back(GLYPH_COUNT - 1);

    // reset window has zero height: the draw produces nothing
    draw_glyph(0, 0, 0, 32'hFFFF_FFFF);
    drain();

    // small 8x8 window at (4,4): cuts on every side
    set_window(4, 4, 8, 8, 640);
    draw_glyph(0, 0, 0, 32'hFFFF_FFFF);          // left, top and bottom cut
    draw_glyph(255, 8, 10, 32'h0000_0000);       // right cut, two rows
    draw_glyph(0, 4, 4, 32'h1234_5678);          // top-left flush
    draw_glyph(255, -32768, -32768, 32'hA5A5_A5A5);
    draw_glyph(0, 32767, 32767, 32'h5A5A_5A5A);
    draw_glyph(255, 2, -12, 32'hDEAD_BEEF);      // all rows above window
    draw_glyph(0, 12, 0, 32'h0F0F_0F0F);         // rows visible, no columns
    drain();

    // far bottom rows with the widest pitch: index crosses the sign bit;
    // zero width gives empty masks on every emitted row
    set_window(0, 32767, 0, 32767, 65535);
    draw_glyph(255, 32767, 32767, 32'h8000_0001);
    draw_glyph(0, -1, 32770, 32'h7FFF_FFFE);
    drain();

    // zero pitch: every row lands on index pos_x, negative x included
    set_window(0, 0, 32767, 32767, 0);
    draw_glyph(0, -32768, 0, 32'hCAFE_F00D);
    draw_glyph(255, 5, 20, 32'h0000_FFFF);
    drain();

    // window at the far corner with zero height
    set_window(32767, 0, 32767, 0, 1);
    draw_glyph(0, 32767, 0, 32'hFFFF_0000);

    // Random part: six windows. Mostly draws of loaded glyphs placed around
    // the crop edges, mixed with whole-glyph reloads and stray byte loads.
    for (phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        0: set_window(0, 0, 32767, 32767, 65535);
        1: set_window($urandom_range(200), $urandom_range(200), $urandom_range(30),
                      $urandom_range(30), $urandom_range(65535, 1));
        2: set_window(32767, 32767, 32767, 32767, 1);
        3: set_window($urandom_range(32767), $urandom_range(32767), 0,
                      $urandom_range(32767), 0);
        default: set_window($urandom_range(65535), $urandom_range(65535),
                            $urandom_range(65535), $urandom_range(65535),
                            $urandom_range(65535));
      endcase
      phase_end = item_count + 85;
      while (item_count < phase_end) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          g = ready_glyphs[$urandom_range(ready_glyphs.size() - 1)];
          x = ($urandom_range(3) != 0) ? near_edge(sb.crop_left, sb.crop_width, 12)
                                       : int'($urandom);
          y = ($urandom_range(3) != 0) ? near_edge(sb.crop_top, sb.crop_height, 18)
                                       : int'($urandom);
          draw_glyph(g, x, y, $urandom);
        end else if (pick < 80) begin
          load_glyph($urandom_range(GLYPH_COUNT - 1));
        end else begin
          // stray byte: rewrites a row but never leaves a drawn glyph unloaded
          load_byte(int'($urandom), 8'($urandom));
        end
      end
    end

    drain();
    if (sb.due_writes.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d row writes never arrived", $time, sb.due_writes.size());
    end
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
